>>> sv/rbr_pkg.sv
// ----------------------------------------------------------------------------
// rbr_pkg
// Types, register codes, group tables and packing helpers for the raw Bayer
// repacker.
// ----------------------------------------------------------------------------
package rbr_pkg;

    localparam int MaxWidthDefault = 16384;
    localparam int GroupMaxOut     = 6;

    localparam logic [1:0] REG_MODE       = 2'd0;
    localparam logic [1:0] REG_ROW_WIDTH  = 2'd1;
    localparam logic [1:0] REG_ROW_STRIDE = 2'd2;

    localparam logic [2:0] MODE_RAW10_PACK = 3'd0;
    localparam logic [2:0] MODE_LOOSE      = 3'd1;
    localparam logic [2:0] MODE_16_TO_10   = 3'd2;
    localparam logic [2:0] MODE_RAW10_16   = 3'd3;
    localparam logic [2:0] MODE_RAW12_PACK = 3'd4;
    localparam logic [2:0] MODE_16_TO_12   = 3'd5;
    localparam logic [2:0] MODE_16BIT      = 3'd6;

    typedef struct packed {
        logic [2:0]  mode;
        logic [14:0] row_width;
        logic [15:0] row_stride;
    } rbr_cfg_t;

    typedef logic [GroupMaxOut-1:0][15:0] rbr_vals_t;

    typedef struct packed {
        logic       valid;
        logic [2:0] count;
        logic       eor;
        rbr_vals_t  vals;
    } rbr_grp_t;

    function automatic logic [3:0] grp_in(input logic [2:0] mode);
        logic [3:0] r;
        begin
            case (mode)
                MODE_RAW10_PACK: r = 4'd5;
                MODE_LOOSE:      r = 4'd8;
                MODE_16_TO_10:   r = 4'd8;
                MODE_RAW10_16:   r = 4'd5;
                MODE_RAW12_PACK: r = 4'd3;
                MODE_16_TO_12:   r = 4'd8;
                MODE_16BIT:      r = 4'd2;
                default:         r = 4'd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [2:0] grp_pix(input logic [2:0] mode);
        logic [2:0] r;
        begin
            case (mode)
                MODE_RAW10_PACK: r = 3'd4;
                MODE_LOOSE:      r = 3'd6;
                MODE_16_TO_10:   r = 3'd4;
                MODE_RAW10_16:   r = 3'd4;
                MODE_RAW12_PACK: r = 3'd2;
                MODE_16_TO_12:   r = 3'd4;
                MODE_16BIT:      r = 3'd1;
                default:         r = 3'd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [4:0][7:0] pack10(input logic [3:0][9:0] p);
        logic [4:0][7:0] o;
        begin
            o[0] = p[0][9:2];
            o[1] = {p[0][1:0], p[1][9:4]};
            o[2] = {p[1][3:0], p[2][9:6]};
            o[3] = {p[2][5:0], p[3][9:8]};
            o[4] = p[3][7:0];
            return o;
        end
    endfunction

    function automatic logic [2:0][7:0] pack12(input logic [11:0] p0, input logic [11:0] p1);
        logic [2:0][7:0] o;
        begin
            o[0] = p0[11:4];
            o[1] = {p0[3:0], p1[11:8]};
            o[2] = p1[7:0];
            return o;
        end
    endfunction

endpackage

>>> sv/rbr_cfg.sv
// ----------------------------------------------------------------------------
// rbr_cfg
// Configuration register bank on an APB-style port.
// ----------------------------------------------------------------------------
module rbr_cfg
    import rbr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output rbr_cfg_t    cfg
);

    rbr_cfg_t   cfg_reg;
    rbr_cfg_t   cfg_next;
    logic       wr_en;
    logic [1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[3:2];
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_MODE:       cfg_next.mode       = pwdata[2:0];
                REG_ROW_WIDTH:  cfg_next.row_width  = pwdata[14:0];
                REG_ROW_STRIDE: cfg_next.row_stride = pwdata[15:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_MODE:       prdata = {29'd0, cfg_reg.mode};
            REG_ROW_WIDTH:  prdata = {17'd0, cfg_reg.row_width};
            REG_ROW_STRIDE: prdata = {16'd0, cfg_reg.row_stride};
            default:        prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode       <= MODE_RAW10_PACK;
            cfg_reg.row_width  <= 15'd4096;
            cfg_reg.row_stride <= 16'd5120;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> sv/rbr_unpack.sv
// ----------------------------------------------------------------------------
// rbr_unpack
// Group collector, row tracking and single-pass group repacking.
// ----------------------------------------------------------------------------
module rbr_unpack
    import rbr_pkg::*;
#(
    parameter int MAX_WIDTH = MaxWidthDefault
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  rbr_cfg_t   cfg,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    output logic       in_ready,
    input  logic       buf_free,
    output rbr_grp_t   grp
);

    localparam logic [15:0] MaxW = 16'(MAX_WIDTH);

    logic [7:0]      bytes_reg [8];
    logic [3:0]      fill_reg;
    logic [3:0]      fill_next;
    logic [15:0]     bpos_reg;
    logic [15:0]     bpos_next;
    logic [14:0]     ppos_reg;
    logic [14:0]     ppos_next;

    logic [14:0]     w;
    logic [3:0]      gin;
    logic [2:0]      gpx;
    logic            active;
    logic            completes;
    logic            accept;
    logic [4:0]      fill_inc;
    logic [15:0]     ppos_sum;
    logic [14:0]     avail;
    logic [7:0][7:0] gb;
    logic [3:0][9:0] p10;
    logic [3:0][9:0] p16;
    logic [4:0][7:0] o10;
    logic [4:0][7:0] o16;
    logic [2:0][7:0] o12;
    logic [2:0][7:0] o12a;
    logic [2:0][7:0] o12b;
    logic [63:0]     loose;
    rbr_vals_t       vals;
    logic [2:0]      count;

    assign w        = ({1'b0, cfg.row_width} < MaxW) ? cfg.row_width : MaxW[14:0];
    assign gin      = grp_in(cfg.mode);
    assign gpx      = grp_pix(cfg.mode);
    assign active   = (gin != 4'd0) && (ppos_reg < w);
    assign fill_inc = {1'b0, fill_reg} + 5'd1;
    assign completes = active && (fill_inc >= {1'b0, gin});
    assign in_ready = !completes || buf_free;
    assign accept   = in_valid && in_ready;
    assign ppos_sum = {1'b0, ppos_reg} + {13'd0, gpx};
    assign avail    = w - ppos_reg;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            gb[i] = bytes_reg[i];
        end
        gb[fill_reg[2:0]] = in_byte;
        for (int i = 0; i < 4; i++)
        begin
            p10[i] = {gb[i], gb[4][2*i +: 2]};
            p16[i] = {gb[2*i+1][1:0], gb[2*i]};
        end
        loose = gb;
        o10   = pack10(p10);
        o16   = pack10(p16);
        o12   = pack12({gb[0], gb[2][3:0]}, {gb[1], gb[2][7:4]});
        o12a  = pack12({gb[1][3:0], gb[0]}, {gb[3][3:0], gb[2]});
        o12b  = pack12({gb[5][3:0], gb[4]}, {gb[7][3:0], gb[6]});
    end

    always_comb
    begin
        vals  = '0;
        count = 3'd0;
        case (cfg.mode)
            MODE_RAW10_PACK:
            begin
                for (int k = 0; k < 5; k++)
                begin
                    vals[k] = {8'd0, o10[k]};
                end
                count = 3'd5;
            end
            MODE_LOOSE:
            begin
                for (int k = 0; k < 6; k++)
                begin
                    vals[k] = {6'd0, loose[10*k +: 10]};
                end
                count = (avail >= 15'd6) ? 3'd6 : avail[2:0];
            end
            MODE_16_TO_10:
            begin
                for (int k = 0; k < 5; k++)
                begin
                    vals[k] = {8'd0, o16[k]};
                end
                count = 3'd5;
            end
            MODE_RAW10_16:
            begin
                for (int k = 0; k < 4; k++)
                begin
                    vals[k] = {6'd0, p10[k]};
                end
                count = (avail >= 15'd4) ? 3'd4 : avail[2:0];
            end
            MODE_RAW12_PACK:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    vals[k] = {8'd0, o12[k]};
                end
                count = 3'd3;
            end
            MODE_16_TO_12:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    vals[k]   = {8'd0, o12a[k]};
                    vals[k+3] = {8'd0, o12b[k]};
                end
                count = 3'd6;
            end
            MODE_16BIT:
            begin
                vals[0] = {gb[1], gb[0]};
                count   = 3'd1;
            end
            default:
            begin
                vals  = '0;
                count = 3'd0;
            end
        endcase
    end

    always_comb
    begin
        fill_next = fill_reg;
        ppos_next = ppos_reg;
        bpos_next = bpos_reg;
        grp.valid = 1'b0;
        grp.count = count;
        grp.eor   = 1'b0;
        grp.vals  = vals;
        if (accept)
        begin
            if (active)
            begin
                if (completes)
                begin
                    fill_next = 4'd0;
                    grp.valid = (count != 3'd0);
                    if (ppos_sum >= {1'b0, w})
                    begin
                        grp.eor   = 1'b1;
                        ppos_next = w;
                    end
                    else
                    begin
                        ppos_next = ppos_sum[14:0];
                    end
                end
                else
                begin
                    fill_next = fill_inc[3:0];
                end
            end
            if (bpos_reg == (cfg.row_stride - 16'd1))
            begin
                bpos_next = 16'd0;
                fill_next = 4'd0;
                ppos_next = 15'd0;
            end
            else
            begin
                bpos_next = bpos_reg + 16'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && active)
        begin
            bytes_reg[fill_reg[2:0]] <= in_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= 4'd0;
            bpos_reg <= 16'd0;
            ppos_reg <= 15'd0;
        end
        else
        begin
            fill_reg <= fill_next;
            bpos_reg <= bpos_next;
            ppos_reg <= ppos_next;
        end
    end

    a_fill_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg[3] == 1'b0)
        else $error("group fill beyond store depth");

endmodule

>>> sv/rbr_outbuf.sv
// ----------------------------------------------------------------------------
// rbr_outbuf
// Result register bank: holds one repacked group and hands it out one
// transfer at a time.
// ----------------------------------------------------------------------------
module rbr_outbuf
    import rbr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  rbr_grp_t    grp,
    output logic        buf_free,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] out_value,
    output logic        out_eor,
    output logic        out_last
);

    rbr_vals_t  vals_reg;
    rbr_vals_t  vals_next;
    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;
    logic       eor_reg;
    logic       eor_next;
    logic       pop;

    assign out_valid = (cnt_reg != 3'd0);
    assign pop       = out_valid && out_ready;
    assign buf_free  = (cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && out_ready);
    assign out_value = vals_reg[0];
    assign out_last  = (cnt_reg == 3'd1);
    assign out_eor   = out_last && eor_reg;

    always_comb
    begin
        vals_next = vals_reg;
        cnt_next  = cnt_reg;
        eor_next  = eor_reg;
        if (grp.valid)
        begin
            vals_next = grp.vals;
            cnt_next  = grp.count;
            eor_next  = grp.eor;
        end
        else if (pop)
        begin
            for (int i = 0; i < GroupMaxOut - 1; i++)
            begin
                vals_next[i] = vals_reg[i+1];
            end
            cnt_next = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        vals_reg <= vals_next;
        eor_reg  <= eor_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 3'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'd6)
        else $error("result count out of range");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        grp.valid |-> buf_free)
        else $error("group loaded over pending results");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !grp.valid) |=> (cnt_reg == $past(cnt_reg) - 3'd1))
        else $error("result count did not advance");

endmodule

>>> sv/raw_bayer_repacker.sv
// ----------------------------------------------------------------------------
// raw_bayer_repacker
// Raw sensor byte stream repacker: RAW10/RAW12/loose/16-bit unpack and pack.
// ----------------------------------------------------------------------------
// One input byte is taken per cycle. A byte that completes a group (2 to 8
// bytes, by mode) loads up to six results into the result register bank in
// the same edge; the bank drains one transfer per cycle while m_tready is high.
// A completing byte waits while two or more results are pending, or one is
// pending and not taken, so with m_tready high the rate is one byte per cycle.
// Bytes past the row width up to the row stride are skipped with no output.
module raw_bayer_repacker
    import rbr_pkg::*;
#(
    parameter int MAX_WIDTH = MaxWidthDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] out_value
    output logic        m_tlast,   // end_of_row
    output logic [0:0]  m_tuser    // [0] last_of_run
);

    rbr_cfg_t cfg;
    rbr_grp_t grp;
    logic     buf_free;
    logic     last;

    rbr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rbr_unpack #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_unpack (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (s_tvalid),
        .in_byte  (s_tdata),
        .in_ready (s_tready),
        .buf_free (buf_free),
        .grp      (grp)
    );

    rbr_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .grp       (grp),
        .buf_free  (buf_free),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_value (m_tdata),
        .out_eor   (m_tlast),
        .out_last  (last)
    );

    assign m_tuser = last;

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the raw Bayer repacker. A directed table covers the
// reset registers, every packing and unpacking mode, mode seven, zero and
// clamped widths, short strides and partial last groups. Random register
// settings follow, each driving whole rows of random bytes or part of a long
// row. Repacked words are predicted per accepted byte and compared in order.
// ----------------------------------------------------------------------------
module tb_top;
    import rbr_pkg::*;

    localparam int          PIX_CAP     = MaxWidthDefault;
    localparam int          RAND_BYTES  = 360;
    localparam int          CALM_BYTES  = 60;
    localparam int          STUCK_LIMIT = 2000;
    localparam int          N_DIR       = 40;
    localparam logic [2:0]  MODE_SKIP_ALL = 3'd7;
    localparam int          BYTES_PER_GROUP [8] = '{5, 8, 8, 5, 3, 8, 2, 0};
    localparam int          PIX_PER_GROUP   [8] = '{4, 6, 4, 4, 2, 4, 1, 0};

    typedef enum logic [2:0] {ST_RD, ST_WR, ST_BYTE, ST_RAND, ST_PAD} step_kind_t;

    typedef struct packed {
        step_kind_t  kind;
        logic [1:0]  idx;
        logic [31:0] arg;
        logic [7:0]  cnt;
        logic        typed;
        logic [15:0] want;
    } step_t;

    typedef struct packed {
        logic [15:0] value;
        logic        eor;
        logic        last;
    } out_word_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] in_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [15:0] out_value
    logic        m_tlast;
    logic [0:0]  m_tuser;   // [0] last_of_run

    logic [2:0]  cur_mode   = MODE_RAW10_PACK;
    logic [14:0] cur_width  = 15'd4096;
    logic [15:0] cur_stride = 16'd5120;
    logic [7:0]  grp_buf [8];
    logic [3:0]  grp_fill   = 4'd0;
    logic [15:0] row_bpos   = 16'd0;
    int          row_ppos   = 0;

    out_word_t   due_words [$];
    int          last_made;
    int          n_bytes;
    int          n_words;
    int          n_row_ends;
    int          n_settings;
    int          n_mismatch;
    int          stuck;
    int          stall_left;
    bit          calm;

    step_t dir_steps [N_DIR] = '{
        '{ST_RD,   REG_MODE,       32'd0,           8'd0, 1'b0, 16'h0000},
        '{ST_RD,   REG_ROW_WIDTH,  32'd4096,        8'd0, 1'b0, 16'h0000},
        '{ST_RD,   REG_ROW_STRIDE, 32'd5120,        8'd0, 1'b0, 16'h0000},
        '{ST_BYTE, REG_MODE,       32'h00FF,        8'd5, 1'b1, 16'h00FF},
        '{ST_WR,   REG_ROW_STRIDE, 32'd8,           8'd0, 1'b0, 16'h0000},
        '{ST_PAD,  REG_MODE,       32'd0,           8'd0, 1'b0, 16'h0000},
        '{ST_WR,   REG_ROW_WIDTH,  32'd4,           8'd0, 1'b0, 16'h0000},
        '{ST_WR,   REG_ROW_STRIDE, 32'd5,           8'd0, 1'b0, 16'h0000},
        '{ST_BYTE, REG_MODE,       32'h0000,        8'd5, 1'b1, 16'h0000},
        '{ST_WR,   REG_MODE,       32'(MODE_16BIT), 8'd0, 1'b0, 16'h0000},
        '{ST_WR,   REG_ROW_STRIDE, 32'd4,           8'd0, 1'b0, 16'h0000},
        '{ST_BYTE, REG_MODE,       32'h0034,        8'd1, 1'b0, 16'h0000},
        '{ST_BYTE, REG_MODE,       32'h0012,        8'd1, 1'b1, 16'h1234},
        '{ST_BYTE, REG_MODE,       32'h00FF,        8'd2, 1'b1, 16'hFFFF},
        '{ST_WR,   REG_MODE,       32'(MODE_SKIP_ALL), 8'd0, 1'b0, 16'h0000},
        '{ST_WR,   REG_ROW_STRIDE, 32'd2,           8'd0, 1'b0, 16'h0000},
        '{ST_RAND, REG_MODE,       32'd0,           8'd2, 1'b0, 16'h0000},
        '{ST_WR,   REG_MODE,       32'(MODE_16BIT), 8'd0, 1'b0, 16'h0000},
        '{ST_WR,   REG_ROW_WIDTH,  32'd0,           8'd0, 1'b0, 16'h0000},
        '{ST_RAND, REG_MODE,       32'd0,           8'd2, 1'b0, 16'h0000},
        '{ST_WR,   REG_ROW_WIDTH,  32'd32767,       8'd0, 1'b0, 16'h0000},
        '{ST_WR,   REG_ROW_STRIDE, 32'd0,           8'd0, 1'b0, 16'h0000},
        '{ST_BYTE, REG_MODE,       32'h0000,        8'd2, 1'b1, 16'h0000},
        '{ST_WR,   REG_ROW_STRIDE, 32'd3,           8'd0, 1'b0, 16'h0000},
        '{ST_PAD,  REG_MODE,       32'd0,           8'd0, 1'b0, 16'h0000},
        '{ST_WR,   REG_MODE,       32'(MODE_LOOSE), 8'd0, 1'b0, 16'h0000},
        '{ST_WR,   REG_ROW_WIDTH,  32'd4,           8'd0, 1'b0, 16'h0000},
        '{ST_WR,   REG_ROW_STRIDE, 32'd8,           8'd0, 1'b0, 16'h0000},
        '{ST_BYTE, REG_MODE,       32'h00FF,        8'd8, 1'b1, 16'h03FF},
        '{ST_WR,   REG_MODE,       32'(MODE_16_TO_10), 8'd0, 1'b0, 16'h0000},
        '{ST_RAND, REG_MODE,       32'd0,           8'd8, 1'b0, 16'h0000},
        '{ST_WR,   REG_MODE,       32'(MODE_RAW10_16), 8'd0, 1'b0, 16'h0000},
        '{ST_WR,   REG_ROW_STRIDE, 32'd5,           8'd0, 1'b0, 16'h0000},
        '{ST_RAND, REG_MODE,       32'd0,           8'd5, 1'b0, 16'h0000},
        '{ST_WR,   REG_MODE,       32'(MODE_RAW12_PACK), 8'd0, 1'b0, 16'h0000},
        '{ST_WR,   REG_ROW_STRIDE, 32'd3,           8'd0, 1'b0, 16'h0000},
        '{ST_RAND, REG_MODE,       32'd0,           8'd3, 1'b0, 16'h0000},
        '{ST_WR,   REG_MODE,       32'(MODE_16_TO_12), 8'd0, 1'b0, 16'h0000},
        '{ST_WR,   REG_ROW_STRIDE, 32'd8,           8'd0, 1'b0, 16'h0000},
        '{ST_RAND, REG_MODE,       32'd0,           8'd8, 1'b0, 16'h0000}
    };

    raw_bayer_repacker u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (n_mismatch < 50)
        begin
            $display("MISMATCH at %0t: %s got %h, want %h", $time, what, got, want);
        end
        n_mismatch++;
    endtask

    function automatic logic [7:0] rand_byte();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
        begin
            return 8'h00;
        end
        if (pick == 1)
        begin
            return 8'hFF;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Advance the group and row counters for one byte and queue its words.
    function automatic int repack_byte(input logic [7:0] b);
        logic [15:0] vals [6];
        logic [9:0]  p10 [4];
        logic [11:0] p12 [4];
        logic [63:0] word;
        int          w;
        int          gin;
        int          gpx;
        int          n;
        int          avail;
        int          npair;
        int          i;
        logic        row_done;
        w        = (int'(cur_width) < PIX_CAP) ? int'(cur_width) : PIX_CAP;
        gin      = BYTES_PER_GROUP[cur_mode];
        gpx      = PIX_PER_GROUP[cur_mode];
        n        = 0;
        row_done = 1'b0;
        if (gin != 0 && row_ppos < w)
        begin
            grp_buf[grp_fill[2:0]] = b;
            grp_fill = grp_fill + 4'd1;
            if (int'(grp_fill) >= gin)
            begin
                avail = w - row_ppos;
                word  = {grp_buf[7], grp_buf[6], grp_buf[5], grp_buf[4],
                         grp_buf[3], grp_buf[2], grp_buf[1], grp_buf[0]};
                for (i = 0; i < 4; i++)
                begin
                    if (cur_mode == MODE_16_TO_10)
                    begin
                        p10[i] = word[16*i +: 10];
                    end
                    else
                    begin
                        p10[i] = {grp_buf[i], grp_buf[4][2*i +: 2]};
                    end
                    p12[i] = word[16*i +: 12];
                end
                if (cur_mode == MODE_RAW12_PACK)
                begin
                    p12[0] = {grp_buf[0], grp_buf[2][3:0]};
                    p12[1] = {grp_buf[1], grp_buf[2][7:4]};
                end
                case (cur_mode)
                    MODE_RAW10_PACK, MODE_16_TO_10:
                    begin
                        vals[0] = {8'h00, p10[0][9:2]};
                        vals[1] = {8'h00, p10[0][1:0], p10[1][9:4]};
                        vals[2] = {8'h00, p10[1][3:0], p10[2][9:6]};
                        vals[3] = {8'h00, p10[2][5:0], p10[3][9:8]};
                        vals[4] = {8'h00, p10[3][7:0]};
                        n = 5;
                    end
                    MODE_LOOSE:
                    begin
                        for (i = 0; i < 6 && i < avail; i++)
                        begin
                            vals[i] = {6'd0, word[10*i +: 10]};
                            n = i + 1;
                        end
                    end
                    MODE_RAW10_16:
                    begin
                        for (i = 0; i < 4 && i < avail; i++)
                        begin
                            vals[i] = {6'd0, p10[i]};
                            n = i + 1;
                        end
                    end
                    MODE_RAW12_PACK, MODE_16_TO_12:
                    begin
                        npair = (cur_mode == MODE_RAW12_PACK) ? 1 : 2;
                        for (i = 0; i < npair; i++)
                        begin
                            vals[3*i]   = {8'h00, p12[2*i][11:4]};
                            vals[3*i+1] = {8'h00, p12[2*i][3:0], p12[2*i+1][11:8]};
                            vals[3*i+2] = {8'h00, p12[2*i+1][7:0]};
                        end
                        n = 3 * npair;
                    end
                    MODE_16BIT:
                    begin
                        vals[0] = word[15:0];
                        n = 1;
                    end
                    default:
                    begin
                        n = 0;
                    end
                endcase
                grp_fill = 4'd0;
                if (row_ppos + gpx >= w)
                begin
                    row_done = 1'b1;
                    row_ppos = w;
                end
                else
                begin
                    row_ppos = row_ppos + gpx;
                end
            end
        end
        if (row_bpos == cur_stride - 16'd1)
        begin
            row_bpos = 16'd0;
            grp_fill = 4'd0;
            row_ppos = 0;
        end
        else
        begin
            row_bpos = row_bpos + 16'd1;
        end
        for (i = 0; i < n; i++)
        begin
            due_words.push_back(out_word_t'{value: vals[i],
                                            eor: (i == n - 1) && row_done,
                                            last: (i == n - 1)});
        end
        return n;
    endfunction

    task automatic push_byte(input logic [7:0] b);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        last_made = repack_byte(b);
        n_bytes++;
    endtask

    task automatic read_reg(input logic [1:0] idx, input logic [31:0] want);
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== want)
        begin
            flag_mismatch("register read", got, want);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MODE:       cur_mode   = val[2:0];
            REG_ROW_WIDTH:  cur_width  = val[14:0];
            REG_ROW_STRIDE: cur_stride = val[15:0];
            default:        ;
        endcase
        n_settings++;
        read_reg(idx, val);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (due_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic run_random_phase();
        logic [2:0]  m;
        logic [14:0] wd;
        logic [15:0] sd;
        int          w;
        int          gin;
        int          gpx;
        int          payload;
        bit          long_row;
        m = ($urandom_range(0, 15) == 0) ? MODE_SKIP_ALL : 3'($urandom_range(0, 6));
        long_row = ($urandom_range(0, 9) == 0);
        case ($urandom_range(0, 6))
            0:       wd = 15'($urandom_range(0, 32767));
            1:       wd = 15'($urandom_range(0, 30));
            default: wd = 15'(4 * $urandom_range(1, 6));
        endcase
        w       = (int'(wd) < PIX_CAP) ? int'(wd) : PIX_CAP;
        gin     = BYTES_PER_GROUP[m];
        gpx     = PIX_PER_GROUP[m];
        payload = (gin == 0) ? 0 : ((w + gpx - 1) / gpx) * gin;
        if (long_row)
        begin
            sd = 16'($urandom_range(32768, 65536));
        end
        else if (payload == 0 || payload > 96 || $urandom_range(0, 3) == 0)
        begin
            sd = 16'($urandom_range(1, 64));
        end
        else
        begin
            sd = 16'(payload + $urandom_range(0, 3));
        end
        if (!long_row && row_bpos != 16'd0 && sd <= row_bpos + 16'd1)
        begin
            sd = row_bpos + 16'd2;
        end
        wait_idle();
        write_reg(REG_MODE, 32'(m));
        write_reg(REG_ROW_WIDTH, 32'(wd));
        write_reg(REG_ROW_STRIDE, 32'(sd));
        if (long_row)
        begin
            repeat ($urandom_range(8, 30)) push_byte(rand_byte());
        end
        else
        begin
            while (row_bpos != 16'd0)
            begin
                push_byte(rand_byte());
            end
            repeat ($urandom_range(1, 3))
            begin
                do
                    push_byte(rand_byte());
                while (row_bpos != 16'd0);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (calm)
        begin
            m_tready <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 5);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Sample away from the driving edge; the transfer completes at the next rise.
    always @(negedge clk)
    begin
        out_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (due_words.size() == 0)
            begin
                flag_mismatch("unexpected transfer", 32'(m_tdata), 32'd0);
            end
            else
            begin
                want = due_words.pop_front();
                if (m_tdata !== want.value)
                begin
                    flag_mismatch("out_value", 32'(m_tdata), 32'(want.value));
                end
                if (m_tlast !== want.eor)
                begin
                    flag_mismatch("end_of_row", 32'(m_tlast), 32'(want.eor));
                end
                if (m_tuser[0] !== want.last)
                begin
                    flag_mismatch("last_of_run", 32'(m_tuser[0]), 32'(want.last));
                end
            end
            n_words++;
            if (m_tlast === 1'b1)
            begin
                n_row_ends++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
        begin
            stuck = 0;
        end
        else
        begin
            stuck++;
        end
        if (stuck >= STUCK_LIMIT)
        begin
            $display("Stalled for %0d cycles with %0d words outstanding",
                     stuck, due_words.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        step_t st;
        int    r;
        int    k;
        int    dir_bytes;
        clk        = 1'b0;
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = 4'd0;
        pwdata     = 32'd0;
        s_tvalid   = 1'b0;
        s_tdata    = 8'd0;
        m_tready   = 1'b1;
        stall_left = 0;
        calm       = 1'b0;
        stuck      = 0;
        n_bytes    = 0;
        n_words    = 0;
        n_row_ends = 0;
        n_settings = 0;
        n_mismatch = 0;
        last_made  = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < N_DIR; r++)
        begin
            st = dir_steps[r];
            case (st.kind)
                ST_RD:
                begin
                    read_reg(st.idx, st.arg);
                end
                ST_WR:
                begin
                    wait_idle();
                    write_reg(st.idx, st.arg);
                end
                ST_BYTE:
                begin
                    repeat (st.cnt)
                    begin
                        push_byte(st.arg[7:0]);
                        if (st.typed)
                        begin
                            for (k = 0; k < last_made; k++)
                            begin
                                due_words[due_words.size() - 1 - k].value = st.want;
                            end
                        end
                    end
                end
                ST_RAND:
                begin
                    repeat (st.cnt) push_byte(rand_byte());
                end
                default:
                begin
                    while (row_bpos != 16'd0)
                    begin
                        push_byte(rand_byte());
                    end
                end
            endcase
        end

        dir_bytes = n_bytes;
        while (n_bytes < dir_bytes + RAND_BYTES)
        begin
            if (n_bytes >= dir_bytes + RAND_BYTES - CALM_BYTES)
            begin
                calm = 1'b1;
            end
            run_random_phase();
        end

        s_tvalid <= 1'b0;
        while (due_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        $display("Sent %0d bytes under %0d register writes in all seven modes and mode seven.",
                 n_bytes, n_settings);
        $display("Checked %0d output words, %0d of them closing a row; %0d mismatches.",
                 n_words, n_row_ends, n_mismatch);
        if (n_mismatch == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> files.f
sv/rbr_pkg.sv
sv/rbr_cfg.sv
sv/rbr_unpack.sv
sv/rbr_outbuf.sv
sv/raw_bayer_repacker.sv
dv/tb_top.sv
